// ----- src/pbt_pkg.sv -----
package pbt_pkg;

  localparam int MAX_EDGE       = 16;
  localparam int MAX_FACE_SLOTS = 64;
  localparam int EDGE_W         = 5;
  localparam int FACE_W         = 7;
  localparam int VERT_W         = 32;
  localparam int CFG_W          = 7;
  localparam int NSLOT          = 3;

  localparam logic [7:0] MODE_FAN    = 8'd1;
  localparam logic [7:0] MODE_CORNER = 8'd2;

  localparam logic KIND_TRI = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic CFG_BLOCK_EDGE = 1'b0;
  localparam logic CFG_MAX_FACES  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [VERT_W-1:0] vert_a;
    logic signed [VERT_W-1:0] vert_b;
    logic signed [VERT_W-1:0] vert_c;
    logic [FACE_W-1:0]        face_count;
    logic                     overflow;
  } res_t;

  // results of one item: slot 0 first triangle, slot 1 second, slot 2 end marker
  typedef struct packed {
    logic [NSLOT-1:0]      v;
    res_t [NSLOT-1:0]      e;
  } batch_t;

  function automatic logic is_pos(logic signed [VERT_W-1:0] x);
    return !x[VERT_W-1] && (x != '0);
  endfunction

  function automatic logic signed [VERT_W-1:0] pick_vert(logic signed [VERT_W-1:0] f,
                                                        logic signed [VERT_W-1:0] b);
    return is_pos(f) ? f : b;
  endfunction

endpackage

// ----- src/pbt_res_q.sv -----
module pbt_res_q
  import pbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  batch_t push_batch,
  input  logic   out_stall,
  output logic   busy,
  output logic   out_valid,
  output res_t   out_res,
  output logic   out_last
);

  batch_t cur_r, cur_nxt;
  batch_t hold_r, hold_nxt;
  logic [NSLOT-1:0] sel, rem;
  logic fire, cur_free;

  always_comb begin
    sel = '0;
    if (cur_r.v[0]) begin
      sel[0] = 1'b1;
    end else if (cur_r.v[1]) begin
      sel[1] = 1'b1;
    end else begin
      sel[2] = cur_r.v[2];
    end
  end

  assign rem       = cur_r.v & ~sel;
  assign out_valid = |cur_r.v;
  assign out_last  = (rem == '0);
  assign fire      = out_valid && !out_stall;
  assign cur_free  = !out_valid || (fire && rem == '0);
  assign busy      = |hold_r.v;

  always_comb begin
    out_res = cur_r.e[2];
    if (sel[0]) begin
      out_res = cur_r.e[0];
    end else if (sel[1]) begin
      out_res = cur_r.e[1];
    end
  end

  always_comb begin
    cur_nxt  = cur_r;
    hold_nxt = hold_r;
    if (cur_free) begin
      if (busy) begin
        // promote the waiting item's results
        cur_nxt    = hold_r;
        hold_nxt.v = '0;
      end else if (push) begin
        cur_nxt = push_batch;
      end else begin
        cur_nxt.v = '0;
      end
    end else begin
      if (fire) begin
        cur_nxt.v = rem;
      end
      if (push) begin
        hold_nxt = push_batch;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r.e  <= cur_nxt.e;
    hold_r.e <= hold_nxt.e;
    if (!rst_n) begin
      cur_r.v  <= '0;
      hold_r.v <= '0;
    end else begin
      cur_r.v  <= cur_nxt.v;
      hold_r.v <= hold_nxt.v;
    end
  end

endmodule

// ----- src/patch_border_triangulator_core.sv -----
// Latency: an item's first result is valid the cycle after acceptance when the result
// stage is free; an item parked in the hold stage waits for the results ahead of it.
// Throughput: one item per cycle, without out_stall, while items yield at most one
// result; an item with more results holds the result port while another waits in hold.
// Reset (rst_n low, synchronous): clears face count, drop flag, pairing state and
// both result stages; block_edge returns to 8 and max_faces to 64.
module patch_border_triangulator_core
  import pbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_mask_code,
  input  logic [1:0]               in_side,
  input  logic [EDGE_W-1:0]        in_position,
  input  logic signed [VERT_W-1:0] in_front_index,
  input  logic signed [VERT_W-1:0] in_back_index,
  input  logic [7:0]               in_back_label,
  input  logic signed [VERT_W-1:0] in_center_vertex,
  input  logic                     in_patch_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_kind,
  output logic signed [VERT_W-1:0] out_vert_a,
  output logic signed [VERT_W-1:0] out_vert_b,
  output logic signed [VERT_W-1:0] out_vert_c,
  output logic [FACE_W-1:0]        out_face_count,
  output logic                     out_overflow,
  output logic                     out_last
);

  logic [EDGE_W-1:0] block_edge_r;
  logic [FACE_W-1:0] max_faces_r;

  logic                     have_prev_r, have_prev_nxt;
  logic signed [VERT_W-1:0] prev_front_r, prev_back_r;
  logic signed [VERT_W-1:0] corner_r [4];
  logic signed [VERT_W-1:0] corner_nxt [4];
  logic [FACE_W-1:0]        faces_r, faces_nxt;
  logic                     dropped_r, dropped_nxt;

  logic [EDGE_W-1:0] edge_sat;
  logic [FACE_W-1:0] limit;
  logic              in_acc, busy;
  logic              hp0, in_range, is_fan, is_corner, fan_take, fan_tri, corner_tri;
  logic              at0, at_e;
  logic              cand0, keep0, keep1;
  logic [FACE_W-1:0] f1, f2;
  logic              drop_any;
  batch_t            batch;
  res_t              out_res;

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  assign edge_sat = (block_edge_r > EDGE_W'(MAX_EDGE)) ? EDGE_W'(MAX_EDGE) : block_edge_r;
  assign limit    = (max_faces_r > FACE_W'(MAX_FACE_SLOTS)) ? FACE_W'(MAX_FACE_SLOTS)
                                                            : max_faces_r;

  assign hp0       = (in_position == '0) ? 1'b0 : have_prev_r;
  assign in_range  = (in_position <= edge_sat);
  assign is_fan    = (in_mask_code == MODE_FAN);
  assign is_corner = (in_mask_code == MODE_CORNER);
  assign fan_take  = in_range && is_fan &&
                     (is_pos(in_front_index) || in_back_label != '0);
  assign fan_tri   = fan_take && hp0;
  assign corner_tri = in_patch_end && is_corner;
  assign at0       = (in_position == '0);
  assign at_e      = (in_position == edge_sat);

  // latch corners; bit 0 of the index is column at edge, bit 1 row at edge
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      corner_nxt[i] = corner_r[i];
    end
    if (in_range && is_corner) begin
      case (in_side)
        2'd0: begin
          if (at0)  corner_nxt[0] = in_back_index;
          if (at_e) corner_nxt[1] = in_back_index;
        end
        2'd1: begin
          if (at0)  corner_nxt[2] = in_back_index;
          if (at_e) corner_nxt[3] = in_back_index;
        end
        2'd2: begin
          if (at0)  corner_nxt[0] = in_back_index;
          if (at_e) corner_nxt[2] = in_back_index;
        end
        default: begin
          if (at0)  corner_nxt[1] = in_back_index;
          if (at_e) corner_nxt[3] = in_back_index;
        end
      endcase
    end
  end

  assign cand0    = fan_tri || corner_tri;
  assign keep0    = cand0 && (faces_r < limit);
  assign f1       = faces_r + FACE_W'(keep0);
  assign keep1    = corner_tri && (f1 < limit);
  assign f2       = f1 + FACE_W'(keep1);
  assign drop_any = dropped_r || (cand0 && !keep0) || (corner_tri && !keep1);

  always_comb begin
    batch = '0;
    batch.v[0] = keep0;
    batch.v[1] = keep1;
    batch.v[2] = in_patch_end;
    batch.e[0].kind = KIND_TRI;
    if (fan_tri) begin
      batch.e[0].vert_a = pick_vert(in_front_index, in_back_index);
      batch.e[0].vert_b = pick_vert(prev_front_r, prev_back_r);
      batch.e[0].vert_c = in_center_vertex;
    end else begin
      batch.e[0].vert_a = corner_nxt[0];
      batch.e[0].vert_b = corner_nxt[1];
      batch.e[0].vert_c = corner_nxt[2];
    end
    batch.e[1].kind   = KIND_TRI;
    batch.e[1].vert_a = corner_nxt[1];
    batch.e[1].vert_b = corner_nxt[2];
    batch.e[1].vert_c = corner_nxt[3];
    batch.e[2].kind       = KIND_END;
    batch.e[2].face_count = f2;
    batch.e[2].overflow   = drop_any;
  end

  always_comb begin
    if (in_patch_end) begin
      have_prev_nxt = 1'b0;
      faces_nxt     = '0;
      dropped_nxt   = 1'b0;
    end else begin
      have_prev_nxt = fan_take ? 1'b1 : hp0;
      faces_nxt     = f2;
      dropped_nxt   = drop_any;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        corner_r[i] <= corner_nxt[i];
      end
      if (fan_take) begin
        prev_front_r <= in_front_index;
        prev_back_r  <= in_back_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_edge_r <= EDGE_W'(8);
      max_faces_r  <= FACE_W'(MAX_FACE_SLOTS);
      have_prev_r  <= 1'b0;
      faces_r      <= '0;
      dropped_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BLOCK_EDGE: block_edge_r <= cfg_data[EDGE_W-1:0];
          CFG_MAX_FACES:  max_faces_r  <= cfg_data[FACE_W-1:0];
        endcase
      end
      if (in_acc) begin
        have_prev_r <= have_prev_nxt;
        faces_r     <= faces_nxt;
        dropped_r   <= dropped_nxt;
      end
    end
  end

  pbt_res_q u_res_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc && (batch.v != '0)),
    .push_batch (batch),
    .out_stall  (out_stall),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .out_last   (out_last)
  );

  assign out_kind       = out_res.kind;
  assign out_vert_a     = out_res.vert_a;
  assign out_vert_b     = out_res.vert_b;
  assign out_vert_c     = out_res.vert_c;
  assign out_face_count = out_res.face_count;
  assign out_overflow   = out_res.overflow;

  a_hold_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("hold stage full while result stage empty");

  a_faces_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    faces_r <= FACE_W'(MAX_FACE_SLOTS))
    else $error("face count above slot limit");

  a_tri_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TRI) |-> (out_face_count == '0 && !out_overflow))
    else $error("triangle carries count or overflow");

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_END) |-> out_last)
    else $error("end marker not last result of its item");

endmodule
